/* rtl/core/bcdcc_pkg.sv */
// bcdcc_pkg: shared types, constants and bcd helpers for the bcd calendar clock.
// Used by the channel interfaces, the check and tick logic and the top level.
// No dependencies.
`default_nettype none

package bcdcc_pkg;

	localparam logic [7:0] SEC_LIMIT   = 8'h60;
	localparam logic [7:0] MIN_LIMIT   = 8'h60;
	localparam logic [7:0] HOUR_LIMIT  = 8'h24;
	localparam logic [7:0] MONTH_MAX   = 8'h12;
	localparam logic [7:0] MONTH_FIRST = 8'h01;
	localparam logic [7:0] DAY_FIRST   = 8'h01;
	localparam logic [7:0] YEAR_LIMIT  = 8'ha0;
	localparam logic [7:0] TENS_MAX    = 8'h90;
	localparam logic [3:0] DIGIT_LIMIT = 4'ha;
	localparam logic [7:0] FEB_LEAP    = 8'h29;
	localparam logic [3:0] MONTH_FEB   = 4'd2;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SET  = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] set_year;
		logic [7:0] set_month;
		logic [7:0] set_day;
		logic [7:0] set_hour;
		logic [7:0] set_minute;
		logic [7:0] set_second;
	} cmd_t;

	typedef struct packed {
		logic [7:0] year_bcd;
		logic [7:0] month_bcd;
		logic [7:0] day_bcd;
		logic [7:0] hour_bcd;
		logic [7:0] minute_bcd;
		logic [7:0] second_bcd;
		logic       time_valid;
	} rsp_t;

	typedef struct packed {
		logic [7:0] year;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
	} bcd_time_t;

	// add one to a bcd byte; tens past 9 wraps the byte to zero
	function automatic logic [7:0] bcd_inc(input logic [7:0] b);
		logic [7:0] n;
		n = b + 8'd1;
		if (n[3:0] > 4'd9) begin
			n = {n[7:4], 4'h0} + 8'h10;
		end
		if ({n[7:4], 4'h0} > TENS_MAX) begin
			n = 8'h00;
		end
		return n;
	endfunction

	function automatic logic [7:0] month_len(input logic [3:0] m);
		logic [7:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 8'h31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 8'h30;
			4'd2:                                       len = 8'h28;
			default:                                    len = 8'h00;
		endcase
		return len;
	endfunction

	// day limit in bcd for the given month and year bytes
	function automatic logic [7:0] day_limit(input logic [7:0] month, input logic [7:0] year);
		logic [7:0] mval;
		logic [1:0] ymod;
		// decoded month value, only its low four bits matter
		mval = {month[7:4], 3'b000} + {3'b000, month[7:4], 1'b0} + {4'h0, month[3:0]};
		// tens * 10 is tens * 2 modulo four
		ymod = {year[4], 1'b0} + year[1:0];
		if (mval[3:0] == MONTH_FEB && ymod == 2'd0) begin
			return FEB_LEAP;
		end
		return month_len(mval[3:0]);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/bcdcc_cmd_if.sv */
// bcdcc_cmd_if: valid/ready channel that carries one command item.
// Depends on bcdcc_pkg for the payload type.
`default_nettype none

interface bcdcc_cmd_if;
	logic             valid;
	logic             ready;
	bcdcc_pkg::cmd_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bcdcc_rsp_if.sv */
// bcdcc_rsp_if: valid/ready channel that carries one result item.
// Depends on bcdcc_pkg for the payload type.
`default_nettype none

interface bcdcc_rsp_if;
	logic             valid;
	logic             ready;
	bcdcc_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bcdcc_check.sv */
// bcdcc_check: bcd digit and range check of a full set of time bytes.
// Depends on bcdcc_pkg.
`default_nettype none

module bcdcc_check (
	input  bcdcc_pkg::bcd_time_t t,
	output logic                 ok
);

	logic digits_ok;
	logic range_ok;
	logic day_ok;

	assign digits_ok = (t.year[3:0] < bcdcc_pkg::DIGIT_LIMIT)
		&& (t.month[3:0] < bcdcc_pkg::DIGIT_LIMIT)
		&& (t.day[3:0] < bcdcc_pkg::DIGIT_LIMIT)
		&& (t.hour[3:0] < bcdcc_pkg::DIGIT_LIMIT)
		&& (t.minute[3:0] < bcdcc_pkg::DIGIT_LIMIT)
		&& (t.second[3:0] < bcdcc_pkg::DIGIT_LIMIT);

	assign range_ok = (t.year < bcdcc_pkg::YEAR_LIMIT)
		&& (t.second < bcdcc_pkg::SEC_LIMIT)
		&& (t.minute < bcdcc_pkg::MIN_LIMIT)
		&& (t.hour < bcdcc_pkg::HOUR_LIMIT)
		&& (t.month >= bcdcc_pkg::MONTH_FIRST)
		&& (t.month <= bcdcc_pkg::MONTH_MAX);

	assign day_ok = (t.day >= bcdcc_pkg::DAY_FIRST)
		&& (t.day <= bcdcc_pkg::day_limit(t.month, t.year));

	assign ok = digits_ok && range_ok && day_ok;

endmodule

`default_nettype wire

/* rtl/core/bcdcc_tick.sv */
// bcdcc_tick: advances a valid bcd time by one second, carry through to the year.
// Depends on bcdcc_pkg.
`default_nettype none

module bcdcc_tick (
	input  bcdcc_pkg::bcd_time_t cur,
	output bcdcc_pkg::bcd_time_t nxt
);

	logic [7:0] sec_i, min_i, hour_i, day_i, month_i, year_i;
	logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;

	always_comb begin
		sec_i   = bcdcc_pkg::bcd_inc(cur.second);
		min_i   = bcdcc_pkg::bcd_inc(cur.minute);
		hour_i  = bcdcc_pkg::bcd_inc(cur.hour);
		day_i   = bcdcc_pkg::bcd_inc(cur.day);
		month_i = bcdcc_pkg::bcd_inc(cur.month);
		year_i  = bcdcc_pkg::bcd_inc(cur.year);

		sec_wrap   = (sec_i >= bcdcc_pkg::SEC_LIMIT);
		min_wrap   = sec_wrap && (min_i >= bcdcc_pkg::MIN_LIMIT);
		hour_wrap  = min_wrap && (hour_i >= bcdcc_pkg::HOUR_LIMIT);
		// day limit is taken from the month before it moves
		day_wrap   = hour_wrap && (day_i > bcdcc_pkg::day_limit(cur.month, cur.year));
		month_wrap = day_wrap && (month_i > bcdcc_pkg::MONTH_MAX);

		nxt.second = sec_wrap ? 8'h00 : sec_i;

		nxt.minute = cur.minute;
		if (sec_wrap) begin
			nxt.minute = min_wrap ? 8'h00 : min_i;
		end

		nxt.hour = cur.hour;
		if (min_wrap) begin
			nxt.hour = hour_wrap ? 8'h00 : hour_i;
		end

		nxt.day = cur.day;
		if (hour_wrap) begin
			nxt.day = day_wrap ? bcdcc_pkg::DAY_FIRST : day_i;
		end

		nxt.month = cur.month;
		if (day_wrap) begin
			nxt.month = month_wrap ? bcdcc_pkg::MONTH_FIRST : month_i;
		end

		nxt.year = month_wrap ? year_i : cur.year;
	end

endmodule

`default_nettype wire

/* rtl/core/bcd_calendar_clock.sv */
// bcd_calendar_clock: top level, input register, time state and result register.
// Depends on bcdcc_pkg, bcdcc_cmd_if, bcdcc_rsp_if, bcdcc_check and bcdcc_tick.
//
// A clock and calendar held as six bcd bytes (year, month, day, hour, minute,
// second). A tick item advances the time by one second, a set item loads all
// six bytes as given; each item returns one result with the bytes after the
// step and a flag that says whether they form a valid time. Ticks on an
// invalid time change nothing. One item is accepted per clock cycle while the
// result side is not stalled: the item is captured in an input register,
// then the tick carry chain or the set check runs in one pass and writes both
// the time state and the result register, which presents the result.
// A stalled result holds the result register and, once the input register is
// also full, the command channel.
// After reset the time is all zero, which reads as invalid.
`default_nettype none

module bcd_calendar_clock (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bcdcc_cmd_if.sink        cmd,
	bcdcc_rsp_if.source      rsp
);

	bcdcc_pkg::cmd_t      item_s1;
	logic                 vld_s1;
	bcdcc_pkg::rsp_t      rsp_s2;
	logic                 vld_s2;

	bcdcc_pkg::bcd_time_t time_q;
	logic                 tvalid_q;

	bcdcc_pkg::bcd_time_t set_time;
	bcdcc_pkg::bcd_time_t tick_time;
	bcdcc_pkg::bcd_time_t time_nxt;
	logic                 set_ok;
	logic                 tvalid_nxt;
	logic                 adv;
	logic                 take;

	assign adv       = !vld_s2 || rsp.ready;
	assign cmd.ready = !vld_s1 || adv;
	assign take      = cmd.valid && cmd.ready;

	assign set_time.year   = item_s1.set_year;
	assign set_time.month  = item_s1.set_month;
	assign set_time.day    = item_s1.set_day;
	assign set_time.hour   = item_s1.set_hour;
	assign set_time.minute = item_s1.set_minute;
	assign set_time.second = item_s1.set_second;

	bcdcc_check u_check (
		.t  (set_time),
		.ok (set_ok)
	);

	bcdcc_tick u_tick (
		.cur (time_q),
		.nxt (tick_time)
	);

	// a tick keeps validity: a valid time stays valid, an invalid one holds
	always_comb begin
		time_nxt   = time_q;
		tvalid_nxt = tvalid_q;
		if (item_s1.func == bcdcc_pkg::FUNC_SET) begin
			time_nxt   = set_time;
			tvalid_nxt = set_ok;
		end else if (tvalid_q) begin
			time_nxt = tick_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			time_q   <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
			if (adv && vld_s1) begin
				time_q   <= time_nxt;
				tvalid_q <= tvalid_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cmd.data;
		end
		if (adv && vld_s1) begin
			rsp_s2.year_bcd   <= time_nxt.year;
			rsp_s2.month_bcd  <= time_nxt.month;
			rsp_s2.day_bcd    <= time_nxt.day;
			rsp_s2.hour_bcd   <= time_nxt.hour;
			rsp_s2.minute_bcd <= time_nxt.minute;
			rsp_s2.second_bcd <= time_nxt.second;
			rsp_s2.time_valid <= tvalid_nxt;
		end
	end

	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking testbench for the bcd calendar clock, with a tick and set predictor.
// Depends on bcdcc_pkg, bcdcc_cmd_if, bcdcc_rsp_if and bcd_calendar_clock.
// Directed edge cases, then random calendar traffic under sender gaps and receiver stalls.
`timescale 1ns / 100ps

module tb;
	import bcdcc_pkg::*;

	logic clk;
	logic arst_n;

	bcdcc_cmd_if cmd_ch ();
	bcdcc_rsp_if rsp_ch ();

	bcd_calendar_clock dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	bcd_time_t clock_now;
	rsp_t      reading_q[$];
	int        mismatches;
	int        send_gap_pct;
	int        recv_stall_pct;
	bit        hold_request;
	int        hold_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int dec(input logic [7:0] b);
		return b[7:4] * 10 + b[3:0];
	endfunction

	function automatic logic [7:0] to_bcd(input int v);
		logic [3:0] tens;
		logic [3:0] ones;
		tens = 4'(v / 10);
		ones = 4'(v % 10);
		return {tens, ones};
	endfunction

	// month length in days; only the low four bits of the decoded month count
	function automatic int days_in(input logic [7:0] month, input logic [7:0] year);
		int m;
		m = dec(month) % 16;
		if (m == 2 && dec(year) % 4 == 0) begin
			return 29;
		end
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return 28;
			default:               return 0;
		endcase
	endfunction

	function automatic bit time_is_good(input bcd_time_t t);
		logic [7:0] b[6];
		b = '{t.year, t.month, t.day, t.hour, t.minute, t.second};
		foreach (b[i]) begin
			if (b[i][3:0] > 4'd9) begin
				return 1'b0;
			end
		end
		// with sound low digits the range checks can be done in decimal
		if (dec(t.year) > 99 || dec(t.second) > 59 || dec(t.minute) > 59) begin
			return 1'b0;
		end
		if (dec(t.hour) > 23 || dec(t.month) < 1 || dec(t.month) > 12) begin
			return 1'b0;
		end
		return dec(t.day) >= 1 && dec(t.day) <= days_in(t.month, t.year);
	endfunction

	function automatic bcd_time_t next_second(input bcd_time_t t);
		int v;
		if (!time_is_good(t)) begin
			return t;
		end
		v = dec(t.second) + 1;
		if (v < 60) begin
			t.second = to_bcd(v);
			return t;
		end
		t.second = 8'h00;
		v = dec(t.minute) + 1;
		if (v < 60) begin
			t.minute = to_bcd(v);
			return t;
		end
		t.minute = 8'h00;
		v = dec(t.hour) + 1;
		if (v < 24) begin
			t.hour = to_bcd(v);
			return t;
		end
		t.hour = 8'h00;
		v = dec(t.day) + 1;
		if (v <= days_in(t.month, t.year)) begin
			t.day = to_bcd(v);
			return t;
		end
		t.day = 8'h01;
		v = dec(t.month) + 1;
		if (v <= 12) begin
			t.month = to_bcd(v);
			return t;
		end
		t.month = 8'h01;
		t.year = to_bcd((dec(t.year) + 1) % 100);
		return t;
	endfunction

	function automatic rsp_t apply_cmd(input cmd_t c);
		rsp_t r;
		if (c.func == FUNC_SET) begin
			clock_now.year   = c.set_year;
			clock_now.month  = c.set_month;
			clock_now.day    = c.set_day;
			clock_now.hour   = c.set_hour;
			clock_now.minute = c.set_minute;
			clock_now.second = c.set_second;
		end else begin
			clock_now = next_second(clock_now);
		end
		r.year_bcd   = clock_now.year;
		r.month_bcd  = clock_now.month;
		r.day_bcd    = clock_now.day;
		r.hour_bcd   = clock_now.hour;
		r.minute_bcd = clock_now.minute;
		r.second_bcd = clock_now.second;
		r.time_valid = time_is_good(clock_now);
		return r;
	endfunction

	// ---------------------------------------------------------------- items

	function automatic cmd_t raw_set();
		cmd_t c;
		c.func       = FUNC_SET;
		c.set_year   = 8'($urandom);
		c.set_month  = 8'($urandom);
		c.set_day    = 8'($urandom);
		c.set_hour   = 8'($urandom);
		c.set_minute = 8'($urandom);
		c.set_second = 8'($urandom);
		return c;
	endfunction

	// set fields of a tick are random, the block must ignore them
	function automatic cmd_t tick_cmd();
		cmd_t c;
		c = raw_set();
		c.func = FUNC_TICK;
		return c;
	endfunction

	function automatic cmd_t set_cmd(input logic [7:0] y, input logic [7:0] mo,
		input logic [7:0] d, input logic [7:0] h, input logic [7:0] mi, input logic [7:0] s);
		cmd_t c;
		c.func       = FUNC_SET;
		c.set_year   = y;
		c.set_month  = mo;
		c.set_day    = d;
		c.set_hour   = h;
		c.set_minute = mi;
		c.set_second = s;
		return c;
	endfunction

	// valid time, biased toward the ends of each field so carries ripple far
	function automatic cmd_t valid_set();
		int y;
		int mo;
		int lim;
		y   = ($urandom_range(7) == 0) ? 99 : $urandom_range(99);
		mo  = ($urandom_range(5) == 0) ? 12 : $urandom_range(12, 1);
		lim = days_in(to_bcd(mo), to_bcd(y));
		return set_cmd(to_bcd(y), to_bcd(mo),
			to_bcd($urandom_range(1) ? lim : $urandom_range(lim, 1)),
			to_bcd($urandom_range(1) ? 23 : $urandom_range(23)),
			to_bcd($urandom_range(1) ? 59 : $urandom_range(59)),
			to_bcd($urandom_range(3) != 0 ? 59 : $urandom_range(59)));
	endfunction

	// break one field: a bad low digit or a value out of its range
	function automatic cmd_t corrupt(input cmd_t c);
		logic [7:0] bad_digit;
		int         lim;
		bad_digit = {4'($urandom_range(15)), 4'($urandom_range(15, 10))};
		lim = days_in(c.set_month, c.set_year);
		case ($urandom_range(5))
			0: c.set_year = $urandom_range(1) ? bad_digit
				: {4'($urandom_range(15, 10)), 4'($urandom_range(9))};
			1: c.set_month = $urandom_range(1) ? bad_digit
				: ($urandom_range(1) ? 8'h00 : to_bcd($urandom_range(99, 13)));
			2: c.set_day = $urandom_range(1) ? bad_digit
				: ($urandom_range(1) ? 8'h00 : to_bcd($urandom_range(99, lim + 1)));
			3: c.set_hour = $urandom_range(1) ? bad_digit : to_bcd($urandom_range(99, 24));
			4: c.set_minute = $urandom_range(1) ? bad_digit : to_bcd($urandom_range(99, 60));
			default: c.set_second = $urandom_range(1) ? bad_digit
				: to_bcd($urandom_range(99, 60));
		endcase
		return c;
	endfunction

	// ---------------------------------------------------------------- channels

	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < send_gap_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		@(posedge clk);
		while (!cmd_ch.ready) begin
			@(posedge clk);
		end
		reading_q.push_back(apply_cmd(c));
	endtask

	task automatic wait_results_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (reading_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin : receiver
		rsp_ch.ready <= 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic check_byte(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (reading_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
			end else begin
				want = reading_q.pop_front();
				check_byte("year_bcd", want.year_bcd, got.year_bcd);
				check_byte("month_bcd", want.month_bcd, got.month_bcd);
				check_byte("day_bcd", want.day_bcd, got.day_bcd);
				check_byte("hour_bcd", want.hour_bcd, got.hour_bcd);
				check_byte("minute_bcd", want.minute_bcd, got.minute_bcd);
				check_byte("second_bcd", want.second_bcd, got.second_bcd);
				check_byte("time_valid", {7'd0, want.time_valid}, {7'd0, got.time_valid});
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic run_calendar_traffic(input int n);
		int   sent;
		int   kind;
		cmd_t c;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(9);
			if (kind == 0) begin
				c = raw_set();
			end else if (kind == 1) begin
				c = corrupt(valid_set());
			end else begin
				c = valid_set();
			end
			send_cmd(c);
			sent++;
			repeat ($urandom_range(6, 1)) begin
				send_cmd(tick_cmd());
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		send_cmd(tick_cmd());                  // all-zero time after reset is invalid
		send_cmd(set_cmd(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		send_cmd(set_cmd(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
		send_cmd(tick_cmd());                  // century wrap
		send_cmd(set_cmd(8'h24, 8'h02, 8'h28, 8'h23, 8'h59, 8'h59));
		send_cmd(tick_cmd());                  // leap year goes to the 29th
		send_cmd(set_cmd(8'h24, 8'h02, 8'h29, 8'h23, 8'h59, 8'h59));
		send_cmd(tick_cmd());
		send_cmd(set_cmd(8'h23, 8'h02, 8'h28, 8'h23, 8'h59, 8'h59));
		send_cmd(tick_cmd());
		send_cmd(set_cmd(8'h23, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00));
		send_cmd(tick_cmd());                  // stored but invalid, tick must not move it
		send_cmd(set_cmd(8'h21, 8'h04, 8'h30, 8'h23, 8'h59, 8'h59));
		send_cmd(tick_cmd());
		send_cmd(set_cmd(8'h00, 8'h02, 8'h29, 8'h12, 8'h34, 8'h56));
		send_cmd(set_cmd(8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
		send_cmd(set_cmd(8'h00, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00));
		send_cmd(set_cmd(8'h00, 8'h0a, 8'h01, 8'h00, 8'h00, 8'h00));
		send_cmd(set_cmd(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
		send_cmd(set_cmd(8'h00, 8'h01, 8'h32, 8'h00, 8'h00, 8'h00));
		send_cmd(set_cmd(8'h00, 8'h01, 8'h01, 8'h24, 8'h00, 8'h00));
		send_cmd(set_cmd(8'h00, 8'h01, 8'h01, 8'h00, 8'h60, 8'h00));
		send_cmd(set_cmd(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h60));
		send_cmd(set_cmd(8'ha0, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
		send_cmd(set_cmd(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h5a));
		send_cmd(tick_cmd());
		wait_results_drained();
	endtask

	task automatic test_streaming();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_calendar_traffic(200);
		wait_results_drained();
	endtask

	task automatic test_sender_gaps();
		send_gap_pct = 57;
		recv_stall_pct = 0;
		run_calendar_traffic(200);
		wait_results_drained();
	endtask

	task automatic test_receiver_stalls();
		send_gap_pct = 0;
		recv_stall_pct = 57;
		run_calendar_traffic(200);
		wait_results_drained();
	endtask

	task automatic test_light_idle();
		send_gap_pct = 8;
		recv_stall_pct = 8;
		run_calendar_traffic(200);
		wait_results_drained();
	endtask

	// long receiver hold-off while items keep coming, so the input side backs up
	task automatic test_fill_and_stall();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		run_calendar_traffic(40);
		wait_results_drained();
	endtask

	task automatic test_pause_until_drained();
		send_gap_pct = 20;
		recv_stall_pct = 20;
		repeat (6) begin
			run_calendar_traffic(5);
			wait_results_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data  <= '0;
		clock_now = '0;
		mismatches = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_light_idle();
		test_fill_and_stall();
		test_pause_until_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && reading_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/bcdcc_pkg.sv
rtl/core/bcdcc_cmd_if.sv
rtl/core/bcdcc_rsp_if.sv
rtl/core/bcdcc_check.sv
rtl/core/bcdcc_tick.sv
rtl/core/bcd_calendar_clock.sv
tb/tb.sv
